[rtl/css_tok_pkg.sv]
// shared types and constants for the css token lexer
`default_nettype none

package css_tok_pkg;

   localparam int RecMax = 6;
   localparam int CountBits = 3;

   localparam logic [4:0] TOK_WS        = 5'd0;
   localparam logic [4:0] TOK_STRING    = 5'd1;
   localparam logic [4:0] TOK_BAD_STR   = 5'd2;
   localparam logic [4:0] TOK_HASH      = 5'd3;
   localparam logic [4:0] TOK_DELIM     = 5'd4;
   localparam logic [4:0] TOK_AT        = 5'd5;
   localparam logic [4:0] TOK_NUMBER    = 5'd6;
   localparam logic [4:0] TOK_PERCENT   = 5'd7;
   localparam logic [4:0] TOK_DIMENSION = 5'd8;
   localparam logic [4:0] TOK_IDENT     = 5'd9;
   localparam logic [4:0] TOK_FUNCTION  = 5'd10;
   localparam logic [4:0] TOK_LBRACE    = 5'd11;
   localparam logic [4:0] TOK_RBRACE    = 5'd12;
   localparam logic [4:0] TOK_LPAREN    = 5'd13;
   localparam logic [4:0] TOK_RPAREN    = 5'd14;
   localparam logic [4:0] TOK_LBRACKET  = 5'd15;
   localparam logic [4:0] TOK_RBRACKET  = 5'd16;
   localparam logic [4:0] TOK_COLON     = 5'd17;
   localparam logic [4:0] TOK_SEMI      = 5'd18;
   localparam logic [4:0] TOK_COMMA     = 5'd19;
   localparam logic [4:0] TOK_AMP       = 5'd20;
   localparam logic [4:0] TOK_GT        = 5'd21;
   localparam logic [4:0] TOK_LT        = 5'd22;
   localparam logic [4:0] TOK_DOT       = 5'd23;
   localparam logic [4:0] TOK_EOF       = 5'd24;

   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   typedef struct packed {
      logic       record_kind;
      logic [4:0] token_type;
      logic [7:0] value_char;
      logic       last_record;
   } rec_type;

   typedef struct packed {
      rec_type [RecMax-1:0]  recs;
      logic [CountBits-1:0]  count;
   } bundle_type;

endpackage

`default_nettype wire

[rtl/css_tok_if.sv]
// request and response channel interfaces
`default_nettype none

interface css_tok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       byte_valid;
   logic       end_of_input;

   modport source (output valid, output text_byte, output byte_valid,
                   output end_of_input, input ready);
   modport sink (input valid, input text_byte, input byte_valid,
                 input end_of_input, output ready);
endinterface

interface css_tok_rsp_if;
   logic       valid;
   logic       ready;
   logic       record_kind;
   logic [4:0] token_type;
   logic [7:0] value_char;
   logic       last_record;

   modport source (output valid, output record_kind, output token_type,
                   output value_char, output last_record, input ready);
   modport sink (input valid, input record_kind, input token_type,
                 input value_char, input last_record, output ready);
endinterface

`default_nettype wire

[rtl/css_tok_front.sv]
// lexer state machine: classifies each byte into a bundle of records
`default_nettype none

module css_tok_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   accept,
   input  wire [7:0]             text_byte,
   input  wire                   byte_valid,
   input  wire                   end_of_input,
   output css_tok_pkg::bundle_type bundle
);
   import css_tok_pkg::*;

   typedef enum logic [3:0] {
      M_IDLE, M_WS, M_STR, M_HASH0, M_HASH, M_AT, M_IDENT, M_NUM, M_DIM, M_DOT
   } mode_type;

   mode_type mode_ff, mode_in;
   logic     quote_ff, quote_in;

   function automatic logic is_space(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_name_start(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_" || c == "-";
   endfunction

   function automatic logic is_name_char(logic [7:0] c);
      return is_name_start(c) || is_digit(c);
   endfunction

   function automatic logic [5:0] punct(logic [7:0] c);
      logic [5:0] r;
      r = 6'd0;
      case (c)
         "{": r = {1'b1, TOK_LBRACE};
         "}": r = {1'b1, TOK_RBRACE};
         "(": r = {1'b1, TOK_LPAREN};
         ")": r = {1'b1, TOK_RPAREN};
         "[": r = {1'b1, TOK_LBRACKET};
         "]": r = {1'b1, TOK_RBRACKET};
         ":": r = {1'b1, TOK_COLON};
         ";": r = {1'b1, TOK_SEMI};
         ",": r = {1'b1, TOK_COMMA};
         "&": r = {1'b1, TOK_AMP};
         ">": r = {1'b1, TOK_GT};
         "<": r = {1'b1, TOK_LT};
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic bundle_type add_rec(bundle_type b, logic kind, logic [4:0] t,
                                          logic [7:0] ch, logic last);
      bundle_type r;
      r = b;
      if (b.count < CountBits'(RecMax)) begin
         r.recs[b.count] = '{record_kind: kind, token_type: t, value_char: ch,
                             last_record: last};
         r.count = b.count + 1'b1;
      end
      return r;
   endfunction

   function automatic bundle_type add_char(bundle_type b, logic [7:0] ch);
      return add_rec(b, KIND_CHAR, TOK_WS, ch, 1'b0);
   endfunction

   function automatic bundle_type add_close(bundle_type b, logic [4:0] t);
      return add_rec(b, KIND_CLOSE, t, 8'd0, 1'b0);
   endfunction

   always_comb begin
      logic       start;
      logic [5:0] p;
      bundle_type b;
      start    = 1'b0;
      p        = punct(text_byte);
      b        = '0;
      mode_in  = mode_ff;
      quote_in = quote_ff;
      if (byte_valid) begin
         unique case (mode_ff)
            M_WS: begin
               if (!is_space(text_byte)) begin
                  b = add_close(b, TOK_WS);
                  start = 1'b1;
               end
            end
            M_STR: begin
               if (text_byte == (quote_ff ? 8'h27 : 8'h22)) begin
                  b = add_close(b, TOK_STRING);
                  mode_in = M_IDLE;
               end else begin
                  b = add_char(b, text_byte);
               end
            end
            M_HASH0: begin
               if (is_name_char(text_byte)) begin
                  b = add_char(b, text_byte);
                  mode_in = M_HASH;
               end else begin
                  b = add_char(b, "#");
                  b = add_close(b, TOK_DELIM);
                  start = 1'b1;
               end
            end
            M_HASH, M_AT, M_DIM: begin
               if (is_name_char(text_byte)) begin
                  b = add_char(b, text_byte);
               end else begin
                  b = add_close(b, (mode_ff == M_HASH) ? TOK_HASH :
                                   (mode_ff == M_AT) ? TOK_AT : TOK_DIMENSION);
                  start = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_name_char(text_byte)) begin
                  b = add_char(b, text_byte);
               end else if (text_byte == "(") begin
                  b = add_close(b, TOK_FUNCTION);
                  mode_in = M_IDLE;
               end else begin
                  b = add_close(b, TOK_IDENT);
                  start = 1'b1;
               end
            end
            M_NUM: begin
               if (is_digit(text_byte) || text_byte == ".") begin
                  b = add_char(b, text_byte);
               end else if (text_byte == "%") begin
                  b = add_close(b, TOK_PERCENT);
                  mode_in = M_IDLE;
               end else if (is_name_start(text_byte)) begin
                  b = add_char(b, text_byte);
                  mode_in = M_DIM;
               end else begin
                  b = add_close(b, TOK_NUMBER);
                  start = 1'b1;
               end
            end
            M_DOT: begin
               if (is_digit(text_byte)) begin
                  b = add_char(b, ".");
                  b = add_char(b, text_byte);
                  mode_in = M_NUM;
               end else begin
                  b = add_close(b, TOK_DOT);
                  start = 1'b1;
               end
            end
            default: start = 1'b1;
         endcase
         if (start) begin
            mode_in = M_IDLE;
            if (is_space(text_byte)) begin
               mode_in = M_WS;
            end else if (text_byte == 8'h22) begin
               mode_in  = M_STR;
               quote_in = 1'b0;
            end else if (text_byte == 8'h27) begin
               mode_in  = M_STR;
               quote_in = 1'b1;
            end else if (text_byte == "#") begin
               mode_in = M_HASH0;
            end else if (text_byte == "@") begin
               mode_in = M_AT;
            end else if (is_digit(text_byte)) begin
               b = add_char(b, text_byte);
               mode_in = M_NUM;
            end else if (text_byte == ".") begin
               mode_in = M_DOT;
            end else if (is_name_start(text_byte)) begin
               b = add_char(b, text_byte);
               mode_in = M_IDENT;
            end else if (p[5]) begin
               b = add_close(b, p[4:0]);
            end else begin
               b = add_char(b, text_byte);
               b = add_close(b, TOK_DELIM);
            end
         end
      end
      if (end_of_input) begin
         unique case (mode_in)
            M_WS:    b = add_close(b, TOK_WS);
            M_STR:   b = add_close(b, TOK_BAD_STR);
            M_HASH0: begin
               b = add_char(b, "#");
               b = add_close(b, TOK_DELIM);
            end
            M_HASH:  b = add_close(b, TOK_HASH);
            M_AT:    b = add_close(b, TOK_AT);
            M_IDENT: b = add_close(b, TOK_IDENT);
            M_NUM:   b = add_close(b, TOK_NUMBER);
            M_DIM:   b = add_close(b, TOK_DIMENSION);
            M_DOT:   b = add_close(b, TOK_DOT);
            default: b = b;
         endcase
         b = add_rec(b, KIND_CLOSE, TOK_EOF, 8'd0, 1'b1);
         mode_in  = M_IDLE;
         quote_in = 1'b0;
      end
      bundle = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         quote_ff <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
      end
   end

endmodule

`default_nettype wire

[rtl/css_tok_fifo.sv]
// short queue of record bundles between front and back
`default_nettype none

module css_tok_fifo #(
   parameter int Depth = 2
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire css_tok_pkg::bundle_type push_data,
   output logic                    full,
   input  wire                     pop,
   output logic                    not_empty,
   output css_tok_pkg::bundle_type head
);
   import css_tok_pkg::*;

   localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntBits = $clog2(Depth + 1);

   bundle_type             mem_ff [Depth];
   logic [PtrBits-1:0]     wr_ff, rd_ff;
   logic [CntBits-1:0]     cnt_ff;

   assign full      = cnt_ff == CntBits'(Depth);
   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rd_ff];

   function automatic logic [PtrBits-1:0] bump(logic [PtrBits-1:0] p);
      return (p == PtrBits'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= bump(wr_ff);
         end
         if (pop) begin
            rd_ff <= bump(rd_ff);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/css_tok_back.sv]
// serializes bundles into one output word per cycle while the receiver is ready
`default_nettype none

module css_tok_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     not_empty,
   input  wire css_tok_pkg::bundle_type head,
   output logic                    pop,
   css_tok_rsp_if.source           rsp_chan
);
   import css_tok_pkg::*;

   logic [CountBits-1:0] idx_ff, idx_in;
   logic                 out_valid_ff, out_valid_in;
   rec_type              out_rec_ff;
   logic                 load;

   always_comb begin
      load         = not_empty && (!out_valid_ff || rsp_chan.ready);
      pop          = load && (idx_ff == head.count - 1'b1);
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         idx_in       = pop ? '0 : idx_ff + 1'b1;
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_rec_ff <= head.recs[idx_ff];
      end
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.record_kind = out_rec_ff.record_kind;
   assign rsp_chan.token_type  = out_rec_ff.token_type;
   assign rsp_chan.value_char  = out_rec_ff.value_char;
   assign rsp_chan.last_record = out_rec_ff.last_record;

endmodule

`default_nettype wire

[rtl/css_token_lexer.sv]
// css token lexer top level
// req_chan takes one source word per handshake: text_byte, byte_valid and
// end_of_input. rsp_chan gives one record word per handshake: a value
// character record or a token close record; last_record marks the end of input.
// the front lexes a word in the cycle it is accepted and writes up to six
// records as one bundle into a queue of QueueDepth bundles; an empty item
// writes nothing. the back drains the head bundle one record per cycle,
// while the receiver takes them, into an output register; a record passes
// through the queue and the output register on its way to rsp_chan.
// req_chan.ready drops only while the queue is full, so a stalled receiver
// holds the output register and backs up the queue before the sender sees it.
// reset (synchronous) returns the lexer to idle between tokens with double
// quote selected, and empties the queue and the output register.
`default_nettype none

module css_token_lexer #(
   parameter int QueueDepth = 2
) (
   input  wire          clock,
   input  wire          reset,
   css_tok_req_if.sink  req_chan,
   css_tok_rsp_if.source rsp_chan
);
   import css_tok_pkg::*;

   bundle_type bundle;
   bundle_type head;
   logic       full, not_empty, pop, accept;

   assign req_chan.ready = !full;
   assign accept         = req_chan.valid && !full;

   css_tok_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .text_byte    (req_chan.text_byte),
      .byte_valid   (req_chan.byte_valid),
      .end_of_input (req_chan.end_of_input),
      .bundle       (bundle)
   );

   css_tok_fifo #(.Depth(QueueDepth)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && bundle.count != '0),
      .push_data (bundle),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   css_tok_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

[test/css_token_lexer_tb.sv]
// self-checking testbench for the css token lexer: directed and random css text under sender idling and receiver stalls
module css_token_lexer_tb;
   import css_tok_pkg::*;

   typedef enum logic [3:0] {
      LX_IDLE, LX_SPACE, LX_STRING, LX_HASH_OPEN, LX_HASH, LX_AT,
      LX_IDENT, LX_NUMBER, LX_DIM, LX_DOT
   } lex_mode_type;

   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   css_tok_req_if req_bus ();
   css_tok_rsp_if rsp_bus ();

   css_token_lexer uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   lex_mode_type lex_mode;
   logic quote_single;
   rec_type expected_recs[$];
   int word_recs;
   int err_count = 0;
   int words_sent = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   function automatic bit is_space(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_name_start(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_" || c == "-";
   endfunction

   function automatic bit is_name_char(logic [7:0] c);
      return is_name_start(c) || is_digit(c);
   endfunction

   function automatic bit punct_token(input logic [7:0] c, output logic [4:0] tok);
      tok = TOK_DELIM;
      case (c)
         "{": tok = TOK_LBRACE;
         "}": tok = TOK_RBRACE;
         "(": tok = TOK_LPAREN;
         ")": tok = TOK_RPAREN;
         "[": tok = TOK_LBRACKET;
         "]": tok = TOK_RBRACKET;
         ":": tok = TOK_COLON;
         ";": tok = TOK_SEMI;
         ",": tok = TOK_COMMA;
         "&": tok = TOK_AMP;
         ">": tok = TOK_GT;
         "<": tok = TOK_LT;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic void push_rec(logic kind, logic [4:0] tok, logic [7:0] ch, logic last);
      rec_type r;
      if (word_recs >= RecMax) return;
      r.record_kind = kind;
      r.token_type = tok;
      r.value_char = ch;
      r.last_record = last;
      expected_recs.push_back(r);
      word_recs++;
   endfunction

   function automatic void push_char(logic [7:0] ch);
      push_rec(KIND_CHAR, '0, ch, 1'b0);
   endfunction

   function automatic void push_close(logic [4:0] tok);
      push_rec(KIND_CLOSE, tok, '0, 1'b0);
   endfunction

   function automatic void lex_start(logic [7:0] c);
      logic [4:0] tok;
      lex_mode = LX_IDLE;
      if (is_space(c)) begin
         lex_mode = LX_SPACE;
      end else if (c == "\"") begin
         lex_mode = LX_STRING;
         quote_single = 1'b0;
      end else if (c == "'") begin
         lex_mode = LX_STRING;
         quote_single = 1'b1;
      end else if (c == "#") begin
         lex_mode = LX_HASH_OPEN;
      end else if (c == "@") begin
         lex_mode = LX_AT;
      end else if (is_digit(c)) begin
         push_char(c);
         lex_mode = LX_NUMBER;
      end else if (c == ".") begin
         lex_mode = LX_DOT;
      end else if (is_name_start(c)) begin
         push_char(c);
         lex_mode = LX_IDENT;
      end else if (punct_token(c, tok)) begin
         push_close(tok);
      end else begin
         push_char(c);
         push_close(TOK_DELIM);
      end
   endfunction

   function automatic void lex_byte(logic [7:0] c);
      bit restart;
      restart = 1'b1;
      case (lex_mode)
         LX_SPACE: begin
            if (is_space(c)) restart = 1'b0;
            else push_close(TOK_WS);
         end
         LX_STRING: begin
            restart = 1'b0;
            if (c == (quote_single ? "'" : "\"")) begin
               push_close(TOK_STRING);
               lex_mode = LX_IDLE;
            end else begin
               push_char(c);
            end
         end
         LX_HASH_OPEN: begin
            if (is_name_char(c)) begin
               push_char(c);
               lex_mode = LX_HASH;
               restart = 1'b0;
            end else begin
               push_char("#");
               push_close(TOK_DELIM);
            end
         end
         LX_HASH: begin
            if (is_name_char(c)) begin
               push_char(c);
               restart = 1'b0;
            end else begin
               push_close(TOK_HASH);
            end
         end
         LX_AT: begin
            if (is_name_char(c)) begin
               push_char(c);
               restart = 1'b0;
            end else begin
               push_close(TOK_AT);
            end
         end
         LX_IDENT: begin
            if (is_name_char(c)) begin
               push_char(c);
               restart = 1'b0;
            end else if (c == "(") begin
               push_close(TOK_FUNCTION);
               lex_mode = LX_IDLE;
               restart = 1'b0;
            end else begin
               push_close(TOK_IDENT);
            end
         end
         LX_NUMBER: begin
            if (is_digit(c) || c == ".") begin
               push_char(c);
               restart = 1'b0;
            end else if (c == "%") begin
               push_close(TOK_PERCENT);
               lex_mode = LX_IDLE;
               restart = 1'b0;
            end else if (is_name_start(c)) begin
               push_char(c);
               lex_mode = LX_DIM;
               restart = 1'b0;
            end else begin
               push_close(TOK_NUMBER);
            end
         end
         LX_DIM: begin
            if (is_name_char(c)) begin
               push_char(c);
               restart = 1'b0;
            end else begin
               push_close(TOK_DIMENSION);
            end
         end
         LX_DOT: begin
            if (is_digit(c)) begin
               push_char(".");
               push_char(c);
               lex_mode = LX_NUMBER;
               restart = 1'b0;
            end else begin
               push_close(TOK_DOT);
            end
         end
         default: ;
      endcase
      if (restart) lex_start(c);
   endfunction

   function automatic void lex_flush();
      case (lex_mode)
         LX_SPACE: push_close(TOK_WS);
         LX_STRING: push_close(TOK_BAD_STR);
         LX_HASH_OPEN: begin
            push_char("#");
            push_close(TOK_DELIM);
         end
         LX_HASH: push_close(TOK_HASH);
         LX_AT: push_close(TOK_AT);
         LX_IDENT: push_close(TOK_IDENT);
         LX_NUMBER: push_close(TOK_NUMBER);
         LX_DIM: push_close(TOK_DIMENSION);
         LX_DOT: push_close(TOK_DOT);
         default: ;
      endcase
      lex_mode = LX_IDLE;
   endfunction

   function automatic void predict_word(logic [7:0] c, logic bv, logic eoi);
      word_recs = 0;
      if (bv) lex_byte(c);
      if (eoi) begin
         lex_flush();
         push_rec(KIND_CLOSE, TOK_EOF, '0, 1'b1);
         lex_mode = LX_IDLE;
         quote_single = 1'b0;
      end
   endfunction

   function automatic logic [7:0] rand_name_start();
      int r;
      r = $urandom_range(53);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + (r - 26));
      return (r == 52) ? "_" : "-";
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(9));
   endfunction

   function automatic logic [7:0] rand_name_char();
      if ($urandom_range(4) == 0) return rand_digit();
      return rand_name_start();
   endfunction

   function automatic logic [7:0] rand_space();
      int r;
      r = $urandom_range(5);
      return (r == 5) ? 8'd32 : 8'(9 + r);
   endfunction

   function automatic logic [7:0] rand_punct();
      string set;
      set = "{}()[]:;,&><";
      return set[$urandom_range(11)];
   endfunction

   task automatic send_word(logic [7:0] c, logic bv, logic eoi);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.text_byte <= c;
      req_bus.byte_valid <= bv;
      req_bus.end_of_input <= eoi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_word(c, bv, eoi);
      if (bv || eoi) words_sent++;
   endtask

   task automatic send_chars(string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, 1'b0);
   endtask

   task automatic random_css(int target);
      int stop_at;
      logic [7:0] q;
      stop_at = words_sent + target;
      while (words_sent < stop_at) begin
         case ($urandom_range(19))
            0, 1, 2: begin
               send_word(rand_name_start(), 1'b1, 1'b0);
               repeat ($urandom_range(4)) send_word(rand_name_char(), 1'b1, 1'b0);
               if ($urandom_range(1)) send_word("(", 1'b1, 1'b0);
            end
            3, 4, 5: begin
               if ($urandom_range(3) == 0) send_word(".", 1'b1, 1'b0);
               repeat ($urandom_range(1, 3)) send_word(rand_digit(), 1'b1, 1'b0);
               if ($urandom_range(2) == 0) begin
                  send_word(".", 1'b1, 1'b0);
                  repeat ($urandom_range(2)) send_word(rand_digit(), 1'b1, 1'b0);
               end
               case ($urandom_range(2))
                  1: send_word("%", 1'b1, 1'b0);
                  2: repeat ($urandom_range(1, 3)) send_word(rand_name_start(), 1'b1, 1'b0);
                  default: ;
               endcase
            end
            6, 7: begin
               q = $urandom_range(1) ? "'" : "\"";
               send_word(q, 1'b1, 1'b0);
               repeat ($urandom_range(5)) begin
                  if ($urandom_range(1)) send_word(rand_name_char(), 1'b1, 1'b0);
                  else send_word(8'($urandom_range(255)), 1'b1, 1'b0);
               end
               if ($urandom_range(7) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
               else send_word(q, 1'b1, 1'b0);
            end
            8: begin
               send_word("#", 1'b1, 1'b0);
               repeat ($urandom_range(3)) send_word(rand_name_char(), 1'b1, 1'b0);
            end
            9: begin
               send_word("@", 1'b1, 1'b0);
               repeat ($urandom_range(3)) send_word(rand_name_char(), 1'b1, 1'b0);
            end
            10, 11: repeat ($urandom_range(1, 3)) send_word(rand_space(), 1'b1, 1'b0);
            12, 13, 14: send_word(rand_punct(), 1'b1, 1'b0);
            15: send_word(".", 1'b1, 1'b0);
            16, 19: send_word(8'($urandom_range(255)), 1'b1, 1'b0);
            17: send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            default: send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
         endcase
      end
   endtask

   task automatic test_directed_tokens();
      idle_pct = 0;
      stall_pct = 0;
      send_chars("f( #1x@,9%.7px#.z");
      send_word(8'hff, 1'b1, 1'b0);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_chars("'q\"'\"");
      // end-only word inside an open string
      send_word(8'h00, 1'b0, 1'b1);
      send_word(".", 1'b1, 1'b1);
   endtask

   task automatic test_random_steady();
      idle_pct = 0;
      stall_pct = 0;
      random_css(58);
   endtask

   task automatic test_random_sender_idle();
      idle_pct = 67;
      stall_pct = 0;
      random_css(58);
   endtask

   task automatic test_random_receiver_stall();
      idle_pct = 0;
      stall_pct = 67;
      random_css(58);
   endtask

   task automatic test_random_both_idle();
      idle_pct = 37;
      stall_pct = 37;
      random_css(58);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rec_type got;
      rec_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.record_kind = rsp_bus.record_kind;
         got.token_type = rsp_bus.token_type;
         got.value_char = rsp_bus.value_char;
         got.last_record = rsp_bus.last_record;
         if (expected_recs.size() == 0) begin
            $write("%0t: unexpected word, expected none, ", $time);
            $display("got kind=%0d type=%0d char=%02h last=%0d",
                     got.record_kind, got.token_type, got.value_char, got.last_record);
            err_count++;
         end else begin
            want = expected_recs.pop_front();
            if (got !== want) begin
               $write("%0t: expected kind=%0d type=%0d char=%02h last=%0d, ",
                      $time, want.record_kind, want.token_type, want.value_char,
                      want.last_record);
               $display("got kind=%0d type=%0d char=%02h last=%0d",
                        got.record_kind, got.token_type, got.value_char,
                        got.last_record);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.text_byte <= '0;
      req_bus.byte_valid <= 1'b0;
      req_bus.end_of_input <= 1'b0;
      lex_mode = LX_IDLE;
      quote_single = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_tokens();
      test_random_steady();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();
      // close whatever token the random text left open
      send_word(8'h00, 1'b0, 1'b1);
      req_bus.valid <= 1'b0;
      while (expected_recs.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (err_count == 0 && expected_recs.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
